/* sv/counting_semaphore_wait_queue_assert.svh */
// Assertion macros used by the semaphore datapath.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

// Check that cond holds at every clock edge out of reset.
`define CSWQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CSWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that cons holds in the same cycle as ante.
`define CSWQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/cswq_pkg.sv */
`default_nettype none
package cswq_pkg;

  typedef enum logic [2:0] {
    ST_ACQUIRED = 3'd0,
    ST_FAILED   = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_RELEASED = 3'd3,
    ST_POSTED   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic {
    MODE_WAIT = 1'b0,
    MODE_POST = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POST = 1'b1
  } state_t;

  typedef struct packed {
    logic wait_step;
    logic post_load;
    logic rel_step;
    logic close;
  } cmd_t;

  typedef struct packed {
    logic q_nonempty;
    logic count_nonzero;
  } stat_t;

endpackage
`default_nettype wire

/* sv/cswq_in_if.sv */
`default_nettype none
interface cswq_in_if #(
  parameter int ID_WIDTH    = 8,
  parameter int COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [ID_WIDTH-1:0]    waiter_id;
  logic                   may_block;
  logic [COUNT_WIDTH-1:0] post_count;

  modport source (output valid, mode, waiter_id, may_block, post_count, input ready);
  modport sink   (input valid, mode, waiter_id, may_block, post_count, output ready);
endinterface
`default_nettype wire

/* sv/cswq_out_if.sv */
`default_nettype none
interface cswq_out_if #(
  parameter int ID_WIDTH    = 8,
  parameter int COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  cswq_pkg::status_t      status;
  logic [ID_WIDTH-1:0]    released_id;
  logic [COUNT_WIDTH-1:0] count_now;
  logic                   last;

  modport source (output valid, status, released_id, count_now, last, input ready);
  modport sink   (input valid, status, released_id, count_now, last, output ready);
endinterface
`default_nettype wire

/* sv/cswq_ctrl.sv */
`default_nettype none
module cswq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cswq_pkg::stat_t stat,
  output cswq_pkg::cmd_t     cmd
);
  import cswq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (in_mode == MODE_WAIT) begin
            cmd.wait_step = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.post_load = 1'b1;
            state_nxt     = S_POST;
          end
        end
      end
      S_POST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (stat.q_nonempty && stat.count_nonzero) begin
            cmd.rel_step = 1'b1;
          end else begin
            cmd.close = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/cswq_dp.sv */
`default_nettype none
`include "counting_semaphore_wait_queue_assert.svh"
module cswq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [COUNT_WIDTH-1:0] cfg_wdata,
  input  wire logic [ID_WIDTH-1:0]    in_waiter_id,
  input  wire logic                   in_may_block,
  input  wire logic [COUNT_WIDTH-1:0] in_post_count,
  input  wire cswq_pkg::cmd_t         cmd,
  output cswq_pkg::stat_t             stat,
  output cswq_pkg::status_t           out_status,
  output logic [ID_WIDTH-1:0]         out_released_id,
  output logic [COUNT_WIDTH-1:0]      out_count_now,
  output logic                        out_last
);
  import cswq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [ID_WIDTH-1:0]    q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  status_t                status_r, status_nxt;
  logic [ID_WIDTH-1:0]    id_r, id_nxt;
  logic [COUNT_WIDTH-1:0] cnt_out_r, cnt_out_nxt;
  logic                   last_r, last_nxt;
  logic                   push;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat;
  logic                   q_full;

  assign q_full = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign sum    = {1'b0, count_r} + {1'b0, in_post_count};
  assign sat    = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

  assign stat.q_nonempty    = (fill_r != '0);
  assign stat.count_nonzero = (count_r != '0);

  assign out_status      = status_r;
  assign out_released_id = id_r;
  assign out_count_now   = cnt_out_r;
  assign out_last        = last_r;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    id_nxt      = id_r;
    cnt_out_nxt = cnt_out_r;
    last_nxt    = last_r;
    push        = 1'b0;
    if (cmd.wait_step) begin
      last_nxt    = 1'b1;
      id_nxt      = '0;
      cnt_out_nxt = count_r;
      if (count_r != '0) begin
        count_nxt   = count_r - 1'b1;
        cnt_out_nxt = count_r - 1'b1;
        status_nxt  = ST_ACQUIRED;
      end else if (!in_may_block) begin
        status_nxt = ST_FAILED;
      end else if (q_full) begin
        status_nxt = ST_FULL;
      end else begin
        push       = 1'b1;
        status_nxt = ST_QUEUED;
        id_nxt     = in_waiter_id;
        tail_nxt   = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        fill_nxt   = fill_r + 1'b1;
      end
    end else if (cmd.post_load) begin
      count_nxt = sat;
    end else if (cmd.rel_step) begin
      count_nxt   = count_r - 1'b1;
      cnt_out_nxt = count_r - 1'b1;
      status_nxt  = ST_RELEASED;
      last_nxt    = 1'b0;
      head_nxt    = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt    = fill_r - 1'b1;
    end else if (cmd.close) begin
      cnt_out_nxt = count_r;
      status_nxt  = ST_POSTED;
      id_nxt      = '0;
      last_nxt    = 1'b1;
    end
    if (cfg_we) begin
      count_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    cnt_out_r <= cnt_out_nxt;
    last_r    <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[tail_r] <= in_waiter_id;
    end
    if (cmd.rel_step) begin
      id_r <= q_mem[head_r];
    end else begin
      id_r <= id_nxt;
    end
  end

  `CSWQ_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(QUEUE_DEPTH),
    "queue fill exceeds depth")
  `CSWQ_ASSERT_SAME(a_rel_legal, clk, rst_n, cmd.rel_step,
    stat.q_nonempty && stat.count_nonzero, "release with empty queue or zero count")
  `CSWQ_ASSERT_NEXT(a_rel_pop, clk, rst_n, cmd.rel_step && !cfg_we,
    fill_r == $past(fill_r) - 1'b1, "release did not pop the queue")
  `CSWQ_ASSERT_SAME(a_ptr_align, clk, rst_n, fill_r == '0, head_r == tail_r,
    "empty queue with head and tail apart")

endmodule
`default_nettype wire

/* sv/counting_semaphore_wait_queue.sv */
// Counting semaphore with a FIFO queue of waiter ids. A wait item gives a
// single result: the controller accepts it and the result register shows
// it in the next cycle. A post item first adds its count to the semaphore
// count with saturation in the cycle it is accepted, then the shared
// count/queue datapath pops one waiter per cycle while the output is not
// stalled, then emits the closing result. A new item is accepted only while
// the controller is idle and the result register is empty or its result is
// taken in the same cycle, so a waiting result holds off the input; output
// back-pressure stalls the release and closing steps. Writing cfg_wdata
// with cfg_we loads the live count and leaves queued waiters in place;
// write it only while the block is idle.
`default_nettype none
module counting_semaphore_wait_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [COUNT_WIDTH-1:0] cfg_wdata,
  cswq_in_if.sink                     in_ch,
  cswq_out_if.source                  out_ch
);
  import cswq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cswq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cswq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_waiter_id    (in_ch.waiter_id),
    .in_may_block    (in_ch.may_block),
    .in_post_count   (in_ch.post_count),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_ch.status),
    .out_released_id (out_ch.released_id),
    .out_count_now   (out_ch.count_now),
    .out_last        (out_ch.last)
  );

endmodule
`default_nettype wire
